>>> design/rsma_pkg.sv
// Package for the running-sum moving average block.
// Holds widths, window constants, controller states and the command/status types.
// No dependencies.
`default_nettype none

package rsma_pkg;

  localparam int unsigned SAMPLE_W   = 24;
  localparam int unsigned AVG_W      = 24;
  localparam int unsigned ENTRIES_W  = 6;
  localparam int unsigned RING_DEPTH = 64;
  localparam int unsigned WINDOW     = 50;
  localparam int unsigned IDX_W      = $clog2(RING_DEPTH);
  localparam int unsigned COUNT_W    = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W      = SAMPLE_W + COUNT_W;
  localparam int unsigned REM_W      = COUNT_W + 1;
  localparam int unsigned STEP_W     = $clog2(SUM_W);
  localparam int unsigned BACK       = WINDOW % RING_DEPTH;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUB,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic accept;
    logic sub;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

>>> design/rsma_ctrl.sv
// Controller for the running-sum moving average block.
// Sequences request accept, window subtract, bit-serial divide and result load.
// Depends on rsma_pkg.
`default_nettype none

module rsma_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire rsma_pkg::sts_t sts_i,
  output rsma_pkg::cmd_t     cmd_o
);
  import rsma_pkg::*;

  state_e state_q;
  state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_SUB;
        end
      end
      ST_SUB: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (sts_i.div_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      ST_SUB: begin
        cmd_o.sub = 1'b1;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
      end
      ST_DONE: begin
        cmd_o.load_out = sts_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && in_valid_i) |=> (state_q == ST_SUB))
    else $error("accepted request did not start the subtract step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && sts_i.div_last) |=> (state_q == ST_DONE))
    else $error("divider finished but controller did not move on");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SUB) |=> (state_q == ST_DIV))
    else $error("subtract step not followed by divide");
`endif

endmodule

`default_nettype wire

>>> design/rsma_dp.sv
// Datapath for the running-sum moving average block.
// Holds the sample ring, index, count, running sum, bit-serial divider and output register.
// Depends on rsma_pkg.
`default_nettype none

module rsma_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [rsma_pkg::SAMPLE_W-1:0] sample_i,
  input  wire rsma_pkg::cmd_t                cmd_i,
  output rsma_pkg::sts_t                     sts_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [rsma_pkg::AVG_W-1:0]         average_o,
  output logic [rsma_pkg::ENTRIES_W-1:0]     entries_o
);
  import rsma_pkg::*;

  logic [SAMPLE_W-1:0]  ring_mem [RING_DEPTH];
  logic [SAMPLE_W-1:0]  old_q;
  logic [IDX_W-1:0]     wi_q;
  logic [IDX_W-1:0]     old_slot;
  logic [COUNT_W-1:0]   count_q;
  logic [COUNT_W-1:0]   count_d;
  logic                 full_q;
  logic [SUM_W-1:0]     sum_q;
  logic [SUM_W-1:0]     sum_sub;
  logic [SUM_W-1:0]     sum_new;
  logic [SUM_W-1:0]     quo_q;
  logic [REM_W-1:0]     rem_q;
  logic [REM_W-1:0]     rem_sh;
  logic                 rem_ge;
  logic [STEP_W-1:0]    step_q;
  logic                 out_valid_q;
  logic [AVG_W-1:0]     out_avg_q;
  logic [ENTRIES_W-1:0] out_ent_q;

  assign old_slot = wi_q - IDX_W'(BACK);
  assign count_d  = (count_q == COUNT_W'(WINDOW)) ? count_q : count_q + COUNT_W'(1);
  assign sum_sub  = (sum_q > SUM_W'(old_q)) ? sum_q - SUM_W'(old_q) : '0;
  assign sum_new  = full_q ? sum_sub : sum_q;
  assign rem_sh   = {rem_q[REM_W-2:0], quo_q[SUM_W-1]};
  assign rem_ge   = rem_sh >= {1'b0, count_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      ring_mem[wi_q] <= sample_i;
      old_q          <= ring_mem[old_slot];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wi_q    <= '0;
      count_q <= '0;
      full_q  <= 1'b0;
      sum_q   <= '0;
      step_q  <= '0;
    end else begin
      if (cmd_i.accept) begin
        wi_q    <= wi_q + IDX_W'(1);
        count_q <= count_d;
        full_q  <= (count_q == COUNT_W'(WINDOW));
        sum_q   <= sum_q + SUM_W'(sample_i);
      end else if (cmd_i.sub) begin
        sum_q  <= sum_new;
        step_q <= '0;
      end else if (cmd_i.div_step) begin
        step_q <= step_q + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sub) begin
      quo_q <= sum_new;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[SUM_W-2:0], rem_ge};
      rem_q <= rem_ge ? rem_sh - {1'b0, count_q} : rem_sh;
    end
  end

  assign sts_o.div_last = (step_q == STEP_W'(SUM_W - 1));
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_avg_q <= quo_q[AVG_W-1:0];
      out_ent_q <= ENTRIES_W'(count_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign average_o   = out_avg_q;
  assign entries_o   = out_ent_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= COUNT_W'(WINDOW))
    else $error("entry count beyond window");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (sum_q == '0))
    else $error("running sum not empty with no entries");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.accept |=> (count_q != '0))
    else $error("count empty after accepted request");
`endif

endmodule

`default_nettype wire

>>> design/running_sum_moving_average_top.sv
// Running-sum moving average: after the accepting edge, the request passes through a window
// subtract, 30 divide steps of the bit-serial restoring divider and a load of the result.
// A new request is taken only after the previous result has been loaded.
// A new request is taken while the previous result waits in the output register.
// Reset clears the write index, entry count, running sum, state and output valid;
// the sample ring is not cleared; a slot is used only after it has been written.
`default_nettype none

module running_sum_moving_average_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [rsma_pkg::SAMPLE_W-1:0] sample_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [rsma_pkg::AVG_W-1:0]         average_o,
  output logic [rsma_pkg::ENTRIES_W-1:0]     entries_o
);
  import rsma_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rsma_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rsma_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sample_i    (sample_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .average_o   (average_o),
    .entries_o   (entries_o)
  );

endmodule

`default_nettype wire
